// ===== hw/rtl/aspect_fit_point_mapper_top_macros.svh =====
`ifndef ASPECT_FIT_POINT_MAPPER_TOP_MACROS_SVH
`define ASPECT_FIT_POINT_MAPPER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define AFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/afpm_pkg.sv =====
`timescale 1ns / 1ps
package afpm_pkg;

  localparam int COORD_W   = 16;
  localparam int DIV_STEPS = 32;
  localparam int PIPE_LEN  = DIV_STEPS + 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_RIGHT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BOTTOM = 4'd7;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;
    logic signed [15:0] dest_left;
    logic signed [15:0] dest_top;
    logic signed [15:0] dest_right;
    logic signed [15:0] dest_bottom;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic signed [16:0] wx;
    logic signed [16:0] wy;
    logic [15:0]        den_x;
    logic [15:0]        den_y;
    logic               ferr;
    logic               merr;
  } fit_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] res;
    if (v > 36'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // divide by two, truncating toward zero
  function automatic logic signed [35:0] half_trunc(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v + $signed({35'b0, v[35]});
    return t >>> 1;
  endfunction

endpackage

// ===== hw/rtl/afpm_fit.sv =====
`timescale 1ns / 1ps
module afpm_fit (
  input  logic           clk,
  input  logic           rst_n,
  input  afpm_pkg::cfg_t cfg,
  input  logic           restart,
  output logic           busy,
  output afpm_pkg::fit_t fit
);
  import afpm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_WID  = 3'd5;

  // divide operations
  localparam logic [1:0] OP_RX = 2'd0;
  localparam logic [1:0] OP_RY = 2'd1;
  localparam logic [1:0] OP_QX = 2'd2;
  localparam logic [1:0] OP_QY = 2'd3;

  localparam logic [4:0] LAST_STEP = 5'(DIV_STEPS - 1);

  logic [2:0]         state_r;
  logic [1:0]         op_r;
  logic [4:0]         cnt_r;
  logic signed [17:0] dx_r, dy_r;
  logic signed [16:0] sxr_r, syr_r;
  logic               ferr_r, both0_r;
  logic [15:0]        sxc_r, syc_r;
  logic [31:0]        p2_r, p3_r;
  logic [31:0]        num_r;
  logic [15:0]        rem_r;
  logic [31:0]        q_r [0:3];
  fit_t               fit_r;

  logic signed [17:0] dx_nxt, dy_nxt;
  logic signed [16:0] sxr_nxt, syr_nxt;
  logic [1:0]         op_nxt;
  logic [31:0]        load_num;
  logic [15:0]        den;
  logic [16:0]        trial;
  logic [17:0]        diff;
  logic [15:0]        rem_nxt;
  logic [31:0]        num_nxt;
  logic signed [35:0] dl, dt, dr, db, m, cx, cy;
  logic signed [35:0] l_w, t_w, r_w, b_w;
  logic               hsel;
  logic signed [16:0] wx_nxt, wy_nxt;

  assign dx_nxt  = 18'(cfg.dest_right) - 18'(cfg.dest_left) - 18'sd2;
  assign dy_nxt  = 18'(cfg.dest_bottom) - 18'(cfg.dest_top) - 18'sd2;
  assign sxr_nxt = 17'(cfg.box_right) - 17'(cfg.box_left);
  assign syr_nxt = 17'(cfg.box_bottom) - 17'(cfg.box_top);

  assign op_nxt = op_r + 2'd1;

  always_comb begin
    case (op_nxt)
      OP_RX:   load_num = {dx_r[15:0], 16'b0};
      OP_RY:   load_num = {dy_r[15:0], 16'b0};
      OP_QX:   load_num = p2_r;
      default: load_num = p3_r;
    endcase
  end

  always_comb begin
    case (op_r) inside
      OP_RX, OP_QY: den = sxc_r;
      default:      den = syc_r;
    endcase
  end

  // restoring divide, one quotient bit per cycle
  assign trial   = {rem_r, num_r[31]};
  assign diff    = {1'b0, trial} - {2'b0, den};
  assign rem_nxt = diff[17] ? trial[15:0] : diff[15:0];
  assign num_nxt = {num_r[30:0], ~diff[17]};

  always_comb begin
    dl   = 36'(cfg.dest_left);
    dt   = 36'(cfg.dest_top);
    dr   = 36'(cfg.dest_right);
    db   = 36'(cfg.dest_bottom);
    hsel = q_r[OP_RX] > q_r[OP_RY];
    cx   = half_trunc(dl + dr);
    cy   = half_trunc(dt + db);
    m    = '0;
    l_w  = dl;
    t_w  = dt;
    r_w  = dr;
    b_w  = db;
    if (ferr_r) begin
      l_w = '0;
      t_w = '0;
      r_w = '0;
      b_w = '0;
    end else if (both0_r) begin
      l_w = cx - 36'sd1;
      r_w = cx + 36'sd1;
      t_w = cy - 36'sd1;
      b_w = cy + 36'sd1;
    end else if (hsel) begin
      m   = (sxc_r == 16'd1) ? half_trunc(36'(dx_r)) - 36'sd1
                             : half_trunc(36'(dx_r) - $signed({4'b0, q_r[OP_QX]}));
      l_w = dl + m;
      r_w = dr - m;
    end else begin
      m   = (syc_r == 16'd1) ? half_trunc(36'(dy_r)) - 36'sd1
                             : half_trunc(36'(dy_r) - $signed({4'b0, q_r[OP_QY]}));
      t_w = dt + m;
      b_w = db - m;
    end
  end

  assign wx_nxt = 17'(fit_r.right) - 17'(fit_r.left);
  assign wy_nxt = 17'(fit_r.bottom) - 17'(fit_r.top);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PREP;
    end else if (restart) begin
      state_r <= ST_PREP;
    end else begin
      unique case (state_r)
        ST_IDLE: state_r <= ST_IDLE;
        ST_PREP: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_DIV;
        ST_DIV: begin
          if (cnt_r == LAST_STEP && op_r == OP_QY) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN:  state_r <= ST_WID;
        ST_WID:  state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        dx_r    <= dx_nxt;
        dy_r    <= dy_nxt;
        sxr_r   <= sxr_nxt;
        syr_r   <= syr_nxt;
        ferr_r  <= (dx_nxt <= 18'sd0) || (dy_nxt <= 18'sd0) || sxr_nxt[16] || syr_nxt[16];
        both0_r <= (sxr_nxt == 17'sd0) && (syr_nxt == 17'sd0);
        sxc_r   <= (sxr_nxt == 17'sd0) ? 16'd1 : sxr_nxt[15:0];
        syc_r   <= (syr_nxt == 17'sd0) ? 16'd1 : syr_nxt[15:0];
      end
      ST_MUL: begin
        p2_r  <= sxc_r * dy_r[15:0];
        p3_r  <= syc_r * dx_r[15:0];
        num_r <= {dx_r[15:0], 16'b0};
        rem_r <= '0;
        cnt_r <= '0;
        op_r  <= OP_RX;
      end
      ST_DIV: begin
        if (cnt_r == LAST_STEP) begin
          q_r[op_r] <= num_nxt;
          op_r      <= op_nxt;
          num_r     <= load_num;
          rem_r     <= '0;
          cnt_r     <= '0;
        end else begin
          num_r <= num_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 5'd1;
        end
      end
      ST_FIN: begin
        fit_r.left   <= sat16(l_w);
        fit_r.top    <= sat16(t_w);
        fit_r.right  <= sat16(r_w);
        fit_r.bottom <= sat16(b_w);
        fit_r.ferr   <= ferr_r;
        fit_r.den_x  <= sxc_r;
        fit_r.den_y  <= syc_r;
      end
      ST_WID: begin
        fit_r.wx   <= wx_nxt;
        fit_r.wy   <= wy_nxt;
        fit_r.merr <= (wx_nxt <= 17'sd0) || (wy_nxt <= 17'sd0) || sxr_r[16] || syr_r[16];
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign fit  = fit_r;

endmodule

// ===== hw/rtl/afpm_axis.sv =====
`timescale 1ns / 1ps
module afpm_axis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               in_fire,
  input  logic signed [15:0] point,
  input  logic signed [15:0] base,
  input  logic signed [16:0] width,
  input  logic [15:0]        den,
  input  logic signed [15:0] offset,
  input  logic               merr,
  output logic               out_vld,
  output logic signed [15:0] out_coord
);
  import afpm_pkg::*;

  logic [PIPE_LEN-1:0] vld_r;
  logic signed [16:0]  sub_r;
  logic signed [33:0]  prod_r;
  logic [31:0]         num_r [0:DIV_STEPS];
  logic [15:0]         rem_r [0:DIV_STEPS];
  logic                neg_r [0:DIV_STEPS];
  logic signed [15:0]  res_r;

  logic signed [33:0] mag_w;
  logic               up;
  logic [32:0]        qmag;
  logic signed [35:0] sval;
  logic signed [35:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_fire};
    end
  end

  assign mag_w = prod_r[33] ? -prod_r : prod_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      sub_r    <= 17'(point) - 17'(base);
      prod_r   <= 34'(sub_r) * 34'(width);
      num_r[0] <= mag_w[31:0];
      rem_r[0] <= '0;
      neg_r[0] <= prod_r[33];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [16:0] trial;
    logic [17:0] diff;
    assign trial = {rem_r[k], num_r[k][31]};
    assign diff  = {1'b0, trial} - {2'b0, den};
    always_ff @(posedge clk) begin
      if (advance) begin
        rem_r[k+1] <= diff[17] ? trial[15:0] : diff[15:0];
        num_r[k+1] <= {num_r[k][30:0], ~diff[17]};
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // round: add one when twice the remainder reaches the divisor
  assign up   = {rem_r[DIV_STEPS], 1'b0} >= {1'b0, den};
  assign qmag = 33'(num_r[DIV_STEPS]) + 33'(up);
  assign sval = neg_r[DIV_STEPS] ? -$signed({3'b0, qmag}) : $signed({3'b0, qmag});
  assign sum  = sval + 36'(offset);

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= merr ? 16'sd0 : sat16(sum);
    end
  end

  assign out_vld   = vld_r[PIPE_LEN-1];
  assign out_coord = res_r;

endmodule

// ===== hw/rtl/aspect_fit_point_mapper_top.sv =====
`timescale 1ns / 1ps
`include "aspect_fit_point_mapper_top_macros.svh"
// Maps one source point per item from the configured box into a centered,
// aspect-kept rectangle inside the destination rectangle. Items are taken one
// per cycle while in_ready is high; each result passes through the per-axis
// divider pipeline (one quotient bit per stage, 32 stages). After reset and
// after every write to index 0 to 7 the fitted rectangle is recomputed by one
// shared bit-serial divider doing four 32-step divides; in_ready stays low
// meanwhile. Register index 8 and above are ignored.
module aspect_fit_point_mapper_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_point_x,
  input  logic signed [15:0]                 in_point_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_mapped_x,
  output logic signed [15:0]                 out_mapped_y,
  output logic signed [15:0]                 out_fit_left,
  output logic signed [15:0]                 out_fit_top,
  output logic signed [15:0]                 out_fit_right,
  output logic signed [15:0]                 out_fit_bottom,
  output logic                               out_fit_error,
  output logic                               out_map_error,
  input  logic                               cfg_we,
  input  logic [afpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afpm_pkg::COORD_W-1:0]       cfg_wdata
);
  import afpm_pkg::*;

  cfg_t cfg_r;
  fit_t fit;
  logic restart;
  logic fit_busy;
  logic advance;
  logic in_fire;
  logic x_vld, y_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_LEFT:    cfg_r.box_left    <= cfg_wdata;
        REG_BOX_TOP:     cfg_r.box_top     <= cfg_wdata;
        REG_BOX_RIGHT:   cfg_r.box_right   <= cfg_wdata;
        REG_BOX_BOTTOM:  cfg_r.box_bottom  <= cfg_wdata;
        REG_DEST_LEFT:   cfg_r.dest_left   <= cfg_wdata;
        REG_DEST_TOP:    cfg_r.dest_top    <= cfg_wdata;
        REG_DEST_RIGHT:  cfg_r.dest_right  <= cfg_wdata;
        REG_DEST_BOTTOM: cfg_r.dest_bottom <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && !cfg_index[CFG_IDX_W-1];

  afpm_fit u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .restart (restart),
    .busy    (fit_busy),
    .fit     (fit)
  );

  assign advance  = !x_vld || out_ready;
  assign in_ready = advance && !fit_busy;
  assign in_fire  = in_valid && in_ready;

  afpm_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_fire   (in_fire),
    .point     (in_point_x),
    .base      (cfg_r.box_left),
    .width     (fit.wx),
    .den       (fit.den_x),
    .offset    (fit.left),
    .merr      (fit.merr),
    .out_vld   (x_vld),
    .out_coord (out_mapped_x)
  );

  afpm_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_fire   (in_fire),
    .point     (in_point_y),
    .base      (cfg_r.box_top),
    .width     (fit.wy),
    .den       (fit.den_y),
    .offset    (fit.top),
    .merr      (fit.merr),
    .out_vld   (y_vld),
    .out_coord (out_mapped_y)
  );

  assign out_valid      = x_vld;
  assign out_fit_left   = fit.left;
  assign out_fit_top    = fit.top;
  assign out_fit_right  = fit.right;
  assign out_fit_bottom = fit.bottom;
  assign out_fit_error  = fit.ferr;
  assign out_map_error  = fit.merr;

  `AFPM_ASSERT_NOW(a_lanes_aligned, 1'b1, x_vld == y_vld, "axis pipelines out of step")
  `AFPM_ASSERT_NOW(a_ferr_implies_merr, out_valid && out_fit_error, out_map_error,
                   "fit error without map error")
  `AFPM_ASSERT_NOW(a_merr_zero_point, out_valid && out_map_error,
                   out_mapped_x == 16'sd0 && out_mapped_y == 16'sd0, "map error point not zero")
  `AFPM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(out_mapped_x) && $stable(out_mapped_y),
                    "stalled item changed")

endmodule

// ===== sim/aspect_fit_point_mapper_top_tb.sv =====
`timescale 1ns / 1ps
module aspect_fit_point_mapper_top_tb;
  import afpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
  } point_t;

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] fl;
    logic signed [15:0] ft;
    logic signed [15:0] fr;
    logic signed [15:0] fb;
    logic               ferr;
    logic               merr;
  } mapped_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_point_x;
  logic signed [15:0] in_point_y;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_mapped_x;
  logic signed [15:0] out_mapped_y;
  logic signed [15:0] out_fit_left;
  logic signed [15:0] out_fit_top;
  logic signed [15:0] out_fit_right;
  logic signed [15:0] out_fit_bottom;
  logic out_fit_error;
  logic out_map_error;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;

  aspect_fit_point_mapper_top u_top (.*);

  point_t pending_points[$];
  mapped_t expected_maps[$];
  logic signed [15:0] regs_model[8];
  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int stall_cycles = 0;
  bit timed_out = 1'b0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint sat(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    return q + (2 * r) / d;
  endfunction

  function automatic mapped_t map_point(point_t p);
    mapped_t e;
    longint bl, bt, br, bb, dl, dt, dr, db, dx, dy, sx, sy, m, wx, wy;
    longint f[4];
    bit ferr;
    bl = regs_model[0]; bt = regs_model[1]; br = regs_model[2]; bb = regs_model[3];
    dl = regs_model[4]; dt = regs_model[5]; dr = regs_model[6]; db = regs_model[7];
    dx = dr - dl - 2;
    dy = db - dt - 2;
    sx = br - bl;
    sy = bb - bt;
    ferr = 0;
    if (dx <= 0 || dy <= 0 || sx < 0 || sy < 0) begin
      ferr = 1;
      f = '{0, 0, 0, 0};
    end else if (sx == 0 && sy == 0) begin
      f[0] = (dl + dr) / 2 - 1;
      f[2] = (dl + dr) / 2 + 1;
      f[1] = (dt + db) / 2 - 1;
      f[3] = (dt + db) / 2 + 1;
    end else begin
      if (sx == 0) sx = 1;
      if (sy == 0) sy = 1;
      if ((dx * 65536) / sx > (dy * 65536) / sy) begin
        m = (sx == 1) ? dx / 2 - 1 : (dx - sx * dy / sy) / 2;
        f = '{dl + m, dt, dr - m, db};
      end else begin
        m = (sy == 1) ? dy / 2 - 1 : (dy - sy * dx / sx) / 2;
        f = '{dl, dt + m, dr, db - m};
      end
    end
    for (int i = 0; i < 4; i++) f[i] = sat(f[i]);
    wx = f[2] - f[0];
    wy = f[3] - f[1];
    sx = br - bl;
    sy = bb - bt;
    if (sx == 0) sx = 1;
    if (sy == 0) sy = 1;
    e.ferr = ferr;
    e.merr = (wx <= 0 || wy <= 0 || sx <= 0 || sy <= 0);
    e.mx = 16'sd0;
    e.my = 16'sd0;
    if (!e.merr) begin
      e.mx = 16'(sat(rdiv((longint'(p.px) - bl) * wx, sx) + f[0]));
      e.my = 16'(sat(rdiv((longint'(p.py) - bt) * wy, sy) + f[1]));
    end
    e.fl = 16'(f[0]);
    e.ft = 16'(f[1]);
    e.fr = 16'(f[2]);
    e.fb = 16'(f[3]);
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_point_x <= '0;
      in_point_y <= '0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          expected_maps.push_back(map_point(p));
          in_valid <= 1'b1;
          in_point_x <= p.px;
          in_point_y <= p.py;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mapped_t got;
      mapped_t want;
      got = '{out_mapped_x, out_mapped_y, out_fit_left, out_fit_top, out_fit_right,
              out_fit_bottom, out_fit_error, out_map_error};
      if (expected_maps.size() == 0) begin
        $display("%0t unexpected item: actual %p", $time, got);
        errors++;
      end else begin
        want = expected_maps.pop_front();
        if (got.mx !== want.mx || got.my !== want.my)
          $display("%0t mapped point: expected %0d,%0d actual %0d,%0d", $time,
                   want.mx, want.my, got.mx, got.my);
        if (got.fl !== want.fl || got.ft !== want.ft || got.fr !== want.fr ||
            got.fb !== want.fb)
          $display("%0t fit rect: expected %0d,%0d,%0d,%0d actual %0d,%0d,%0d,%0d",
                   $time, want.fl, want.ft, want.fr, want.fb, got.fl, got.ft, got.fr,
                   got.fb);
        if (got.ferr !== want.ferr || got.merr !== want.merr)
          $display("%0t error flags: expected %b%b actual %b%b", $time, want.ferr,
                   want.merr, got.ferr, got.merr);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (pending_points.size() > 0 || expected_maps.size() > 0 || in_valid) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end
  end

  task automatic write_reg(int idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 8) regs_model[idx] = val;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_maps.size() > 0) begin
      @(posedge clk);
      if (timed_out) begin
        $display("FAIL aspect_fit_point_mapper_top");
        $finish;
      end
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(i, v[i]);
  endtask

  function automatic logic [15:0] rand_coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(400)) - 200);
  endfunction

  task automatic queue_points(int count, bit wide);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p.px = rand_coord(wide);
      p.py = rand_coord(wide);
      pending_points.push_back(p);
    end
  endtask

  task automatic random_geometry();
    logic [15:0] v[8];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 8; i++) v[i] = rand_coord(kind == 0);
    if (kind >= 2) begin
      if ($signed(v[2]) < $signed(v[0])) v[2] = v[0] + 16'($urandom_range(300));
      if ($signed(v[3]) < $signed(v[1])) v[3] = v[1] + 16'($urandom_range(300));
      v[6] = v[4] + 16'($urandom_range(500, 3));
      v[7] = v[5] + 16'($urandom_range(500, 3));
    end
    set_geometry(v);
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 69;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < 8; i++) regs_model[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: fit error
    pending_points.push_back('{16'sh7fff, 16'sh8000});
    drain();
    // ignored index
    write_reg(REG_DEST_BOTTOM + 1, 16'h1234);
    set_geometry('{16'sd0, 16'sd0, 16'sd100, 16'sd50, 16'sd0, 16'sd0, 16'sd402, 16'sd402});
    pending_points.push_back('{16'sd0, 16'sd0});
    pending_points.push_back('{16'sd100, 16'sd50});
    pending_points.push_back('{16'sh7fff, 16'sh7fff});
    pending_points.push_back('{16'sh8000, 16'sh8000});
    pending_points.push_back('{16'sd50, 16'sd25});
    drain();
    // empty box
    set_geometry('{16'sd5, 16'sd5, 16'sd5, 16'sd5, -16'sd11, 16'sd3, 16'sd20, 16'sd40});
    pending_points.push_back('{16'sd5, 16'sd5});
    pending_points.push_back('{-16'sd7, 16'sd9});
    drain();
    // zero width box, wide extremes, inverted box
    set_geometry('{16'sd7, -16'sd10, 16'sd7, 16'sd90, 16'sh8000, 16'sh8000, 16'sh7fff,
                   16'sh7fff});
    pending_points.push_back('{16'sh7fff, 16'sh8000});
    pending_points.push_back('{16'sd7, 16'sd90});
    drain();
    set_geometry('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd3,
                   16'sd3});
    pending_points.push_back('{16'sh7fff, 16'sh0});
    drain();
    set_geometry('{16'sd10, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd100, 16'sd100});
    pending_points.push_back('{16'sd3, 16'sd3});
    drain();
    set_geometry('{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'sd2, 16'sd100});
    pending_points.push_back('{16'sd3, 16'sd3});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 69;
        recv_idle_pct = 32;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int g = 0; g < 10; g++) begin
        random_geometry();
        queue_points(50, $urandom_range(3) == 0);
        drain();
      end
    end

    if (errors == 0) begin
      $display("PASS aspect_fit_point_mapper_top");
    end else begin
      $display("FAIL aspect_fit_point_mapper_top");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/afpm_pkg.sv
hw/rtl/afpm_fit.sv
hw/rtl/afpm_axis.sv
hw/rtl/aspect_fit_point_mapper_top.sv
sim/aspect_fit_point_mapper_top_tb.sv
